// ----- rtl/percent_decoder_stream_top_assert.svh -----
// Assertion macros shared by the percent decoder checker.
// Plain text only: no dependencies on any package or module.
`ifndef PERCENT_DECODER_STREAM_TOP_ASSERT_SVH
`define PERCENT_DECODER_STREAM_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked across reset as well.
`define PDS_ASSERT_RST(lbl, clk_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pds_pkg.sv -----
// Package for the percent decoder stream: character codes, hex helpers,
// held-state enum and the queue entry type. No dependencies.
`default_nettype none

package pds_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LC_A    = 8'h61;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_UC_A    = 8'h41;
  localparam logic [7:0] CH_UC_F    = 8'h46;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  localparam logic [15:0] CAP_RESET = 16'hFFFF;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_PCT,
    HELD_DIGIT
  } held_t;

  // One accepted item's worth of results, in order.
  typedef struct packed {
    logic [1:0]                 nres;
    logic [MAX_RES-1:0][7:0]    bytes;
    logic [MAX_RES-1:0]         term;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    r = ((c >= CH_ZERO) && (c <= CH_NINE)) ||
        ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
        ((c >= CH_UC_A) && (c <= CH_UC_F));
    return r;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CH_LC_A) begin
      v = c - CH_LC_A + HEX_TEN;
    end else if (c >= CH_UC_A) begin
      v = c - CH_UC_A + HEX_TEN;
    end else begin
      v = c - CH_ZERO;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pds_front.sv -----
// Front end: accepts source items, tracks escape state and the emitted count,
// and pushes the surviving results of each item as one queue entry. Uses pds_pkg.
`default_nettype none

module pds_front import pds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_is_end,
  input  wire logic [15:0] capacity,
  output entry_t           entry,
  output logic             push
);

  held_t       held_r, held_nxt;
  logic [7:0]  digit_r, digit_nxt;
  logic [15:0] ecount_r, ecount_nxt;

  logic [MAX_RES-1:0][7:0] cand;
  logic [1:0]  ncand;
  logic        fresh_emit;
  logic [7:0]  fresh_byte;
  logic [16:0] lim, used, diff;
  logic [1:0]  room, kept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= HELD_NONE;
      ecount_r <= '0;
    end else begin
      held_r   <= held_nxt;
      ecount_r <= ecount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  always_comb begin
    fresh_emit = (in_byte != CH_PERCENT);
    fresh_byte = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    cand       = '0;
    ncand      = 2'd0;
    held_nxt   = held_r;
    digit_nxt  = digit_r;

    if (in_is_end) begin
      cand[0]  = CH_PERCENT;
      cand[1]  = digit_r;
      ncand    = (held_r == HELD_DIGIT) ? 2'd2 : ((held_r == HELD_PCT) ? 2'd1 : 2'd0);
      held_nxt = HELD_NONE;
    end else begin
      unique case (held_r)
        HELD_PCT: begin
          if (is_hex(in_byte)) begin
            held_nxt  = HELD_DIGIT;
            digit_nxt = in_byte;
          end else begin
            cand[0]  = CH_PERCENT;
            cand[1]  = fresh_byte;
            ncand    = fresh_emit ? 2'd2 : 2'd1;
            held_nxt = fresh_emit ? HELD_NONE : HELD_PCT;
          end
        end
        HELD_DIGIT: begin
          if (is_hex(in_byte)) begin
            cand[0]  = {hex_val(digit_r), hex_val(in_byte)};
            ncand    = 2'd1;
            held_nxt = HELD_NONE;
          end else begin
            cand[0]  = CH_PERCENT;
            cand[1]  = digit_r;
            cand[2]  = fresh_byte;
            ncand    = fresh_emit ? 2'd3 : 2'd2;
            held_nxt = fresh_emit ? HELD_NONE : HELD_PCT;
          end
        end
        default: begin
          cand[0]  = fresh_byte;
          ncand    = fresh_emit ? 2'd1 : 2'd0;
          held_nxt = fresh_emit ? HELD_NONE : HELD_PCT;
        end
      endcase
    end

    // Room left before the destination is full, clipped to three.
    lim  = {1'b0, capacity};
    used = {1'b0, ecount_r} + 17'd1;
    diff = lim - used;
    if (used < lim) begin
      room = (diff > 17'd3) ? 2'd3 : diff[1:0];
    end else begin
      room = 2'd0;
    end
    kept = (ncand < room) ? ncand : room;

    for (int k = 0; k < MAX_RES; k++) begin
      entry.bytes[k] = (2'(k) < kept) ? cand[k] : 8'h00;
      entry.term[k]  = in_is_end && (2'(k) == kept);
    end
    entry.nres = kept + {1'b0, in_is_end};
    push       = accept && (entry.nres != 2'd0);

    if (!accept) begin
      held_nxt   = held_r;
      digit_nxt  = digit_r;
      ecount_nxt = ecount_r;
    end else if (in_is_end) begin
      ecount_nxt = '0;
    end else begin
      ecount_nxt = ecount_r + {14'd0, kept};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pds_queue.sv -----
// Short entry queue between the front and back ends.
// Register array with a combinational head read. Uses pds_pkg.
`default_nettype none

module pds_queue import pds_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  entry_t    wr_entry,
  input  wire logic pop,
  output entry_t    head,
  output logic      empty,
  output logic      full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == CW'(0));
  assign full    = (count_r == CW'(DEPTH));
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pds_back.sv -----
// Back end: walks the head queue entry one result per cycle, while out_stall
// is low, into the output register. Uses pds_pkg.
`default_nettype none

module pds_back import pds_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  entry_t          head,
  input  wire logic       empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_is_terminator,
  output logic            out_run_last
);

  logic [1:0] pos_r, pos_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       term_r, term_nxt;
  logic       last_r, last_nxt;
  logic       advance, at_last;

  assign advance = !valid_r || !out_stall;
  assign at_last = (pos_r == head.nres - 2'd1);

  always_comb begin
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    term_nxt  = term_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (advance) begin
      valid_nxt = !empty;
      if (!empty) begin
        byte_nxt = head.bytes[pos_r];
        term_nxt = head.term[pos_r];
        last_nxt = at_last;
        pop      = at_last;
        pos_nxt  = at_last ? 2'd0 : pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    term_r <= term_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_is_terminator = term_r;
  assign out_run_last      = last_r;

endmodule

`default_nettype wire

// ----- rtl/percent_decoder_stream_top.sv -----
// Top level of the streaming URL percent decoder.
// Instantiates pds_front, pds_queue and pds_back; uses pds_pkg.
//
//   channel | signals                                   | dir | handshake
//   --------+-------------------------------------------+-----+--------------------
//   in      | in_byte[7:0], in_is_end                   | in  | in_valid / in_stall
//   out     | out_byte[7:0], out_is_terminator,         | out | out_valid / out_stall
//           | out_run_last                              |     |
//   cfg     | cfg_data[15:0] (destination capacity)     | in  | cfg_valid / cfg_ready
//
// One item is taken per cycle while the entry queue has room; the front end
// classifies it in that cycle. The back end gives one result item per cycle
// while out_stall is low, showing an item's k results in turn (k is 0 to 3).
// The first result of an item is written into the queue at its acceptance
// edge and passes from there into the output register. rst_n is synchronous:
// it empties the queue and the output register, clears the escape state and
// the emitted count and sets the capacity to 65535. in_stall rises only while
// the queue is full.
`default_nettype none

module percent_decoder_stream_top import pds_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_is_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_is_terminator,
  output logic             out_run_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] capacity_r, capacity_nxt;
  logic        in_accept;
  entry_t      fe_entry, q_head;
  logic        fe_push, q_pop, q_empty, q_full;

  // Capacity writes must arrive only while idle; unenforced, they are taken at once.
  assign cfg_ready    = 1'b1;
  assign capacity_nxt = (cfg_valid && cfg_ready) ? cfg_data : capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // Hold the source off only while the queue cannot take another entry.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  pds_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_byte   (in_byte),
    .in_is_end (in_is_end),
    .capacity  (capacity_r),
    .entry     (fe_entry),
    .push      (fe_push)
  );

  pds_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .wr_entry (fe_entry),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  pds_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .empty             (q_empty),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_is_terminator (out_is_terminator),
    .out_run_last      (out_run_last)
  );

endmodule

`default_nettype wire

// ----- rtl/pds_checker.sv -----
// Port-level checker for percent_decoder_stream_top, bound to it below.
// Depends on percent_decoder_stream_top_assert.svh.
`default_nettype none

`include "percent_decoder_stream_top_assert.svh"

module pds_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_byte,
  input wire logic        out_is_terminator,
  input wire logic        out_run_last
);

  `PDS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_is_terminator) && $stable(out_run_last), "stalled result changed")
  `PDS_ASSERT_IMP(a_term_shape, clk, rst_n, out_valid && out_is_terminator, out_run_last && (out_byte == 8'h00), "terminator not last or not zero")
  `PDS_ASSERT_NXT(a_run_cont, clk, rst_n, out_valid && !out_stall && !out_run_last, out_valid, "gap inside the results of one item")
  `PDS_ASSERT_RST(a_rst_clear, clk, !rst_n, !out_valid, "result shown after reset")

endmodule

bind percent_decoder_stream_top pds_checker u_pds_checker (.*);

`default_nettype wire
